/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL module of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/sfd_pkg.sv */
// Package with the constants and result type of the serial frame deframer.
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] START_CHAR = 8'h40;
  localparam logic [7:0] LINE_FEED  = 8'h0A;

  // Header positions, the start character sits at position one.
  localparam logic [16:0] POS_LEN_LO = 17'd6;
  localparam logic [16:0] POS_LEN_HI = 17'd7;
  localparam logic [16:0] POS_TX     = 17'd8;
  localparam logic [16:0] POS_RX     = 17'd9;
  localparam logic [16:0] POS_COUNT  = 17'd10;

  localparam logic [16:0] TERM_OFFSET = 17'd6;
  localparam logic [15:0] MIN_LENGTH  = 16'd6;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_END_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD_TERM = 2'd2;
  localparam logic [1:0] KIND_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [16:0] frame_position;
    logic [15:0] bin_length;
    logic [7:0]  tx_node;
    logic [7:0]  rx_node;
    logic [7:0]  msg_count;
    logic [7:0]  msg_type;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sonar_frame_deframer.sv */
// Top level of the serial frame deframer: header capture, payload tagging and skid output.
// Results are registered: in the output register, or in the skid register while that is held.
// Throughput: one input beat per cycle; the output register plus a one-entry skid register
// let the input run on while a result waits, and input stall rises only when the skid is full.
// Reset (asynchronous, active low) returns the block to hunting for the start character and
// empties both output registers; captured header fields are cleared as well.
`default_nettype none
`include "assert_macros.svh"

module sonar_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [16:0]      frame_position_o,
  output logic [15:0]      bin_length_o,
  output logic [7:0]       tx_node_o,
  output logic [7:0]       rx_node_o,
  output logic [7:0]       msg_count_o,
  output logic [7:0]       msg_type_o
);
  import sfd_pkg::*;

  // Parser phases. The unused code behaves like hunting.
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  typ_q, typ_d;

  result_t     out_q, out_d;
  result_t     skid_q, skid_d;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;

  logic        in_fire;
  logic        out_take;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [16:0] pos_inc;
  logic [16:0] term_pos;
  result_t     res;

  // The input is held back only while the skid register holds a result, so a
  // result that waits on the output never blocks beats that arrive behind it.
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  assign pos_inc  = pos_q + 17'd1;
  assign term_pos = {1'b0, len_q} + TERM_OFFSET;

  // Per-beat parser. The header fields update in place, and a result carries
  // the header as it stands after this beat, so a bad length result already
  // shows the message type that triggered it.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_d     = len_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    cnt_d     = cnt_q;
    typ_d     = typ_q;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;

    if (in_fire) begin
      case (phase_q)
        PH_HEADER: begin
          pos_d = pos_inc;
          if (pos_inc == POS_LEN_LO) begin
            len_d = {8'h00, rx_byte_i};
          end else if (pos_inc == POS_LEN_HI) begin
            len_d = {rx_byte_i, len_q[7:0]};
          end else if (pos_inc == POS_TX) begin
            tx_d = rx_byte_i;
          end else if (pos_inc == POS_RX) begin
            rx_d = rx_byte_i;
          end else if (pos_inc == POS_COUNT) begin
            cnt_d = rx_byte_i;
          end else if (pos_inc > POS_COUNT) begin
            // Message type byte closes the header. A length this short puts
            // the terminator inside the header, so the frame is dropped.
            typ_d = rx_byte_i;
            if (len_q < MIN_LENGTH) begin
              res_valid = 1'b1;
              res_kind  = KIND_BAD_LEN;
              phase_d   = PH_HUNT;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          pos_d     = pos_inc;
          res_valid = 1'b1;
          if (pos_inc == term_pos) begin
            res_kind = (rx_byte_i == LINE_FEED) ? KIND_END_OK : KIND_BAD_TERM;
            phase_d  = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == START_CHAR) begin
            phase_d = PH_HEADER;
            pos_d   = 17'd1;
            len_d   = '0;
            tx_d    = '0;
            rx_d    = '0;
            cnt_d   = '0;
            typ_d   = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.kind           = res_kind;
    res.data_byte      = rx_byte_i;
    res.frame_position = pos_d;
    res.bin_length     = len_d;
    res.tx_node        = tx_d;
    res.rx_node        = rx_d;
    res.msg_count      = cnt_d;
    res.msg_type       = typ_d;
  end

  // Output register with a one-entry skid register behind it. The skid entry
  // is always older than anything new, so it moves up first.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;

    if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end

    if (res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      pos_q        <= '0;
      len_q        <= '0;
      tx_q         <= '0;
      rx_q         <= '0;
      cnt_q        <= '0;
      typ_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
      tx_q         <= tx_d;
      rx_q         <= rx_d;
      cnt_q        <= cnt_d;
      typ_q        <= typ_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign frame_position_o = out_q.frame_position;
  assign bin_length_o     = out_q.bin_length;
  assign tx_node_o        = out_q.tx_node;
  assign rx_node_o        = out_q.rx_node;
  assign msg_count_o      = out_q.msg_count;
  assign msg_type_o       = out_q.msg_type;

  // The skid register only fills behind a waiting output beat.
  `ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  // While in the payload the position never passes the terminator position.
  `ASSERT_CLK(a_data_pos_bound, (phase_q == PH_DATA) |-> (pos_q <= term_pos && pos_q >= 17'd11),
              "payload position out of range")
  // A frame end, good or bad, is reported exactly at the terminator position.
  `ASSERT_CLK(a_end_at_term,
              (out_valid_q && (out_q.kind == KIND_END_OK || out_q.kind == KIND_BAD_TERM)) |->
              (out_q.frame_position == {1'b0, out_q.bin_length} + TERM_OFFSET),
              "frame end reported away from terminator position")
  // A length error is only raised for a length below the minimum.
  `ASSERT_CLK(a_bad_len_short,
              (out_valid_q && out_q.kind == KIND_BAD_LEN) |-> (out_q.bin_length < MIN_LENGTH),
              "length error raised for a valid length")

endmodule

`default_nettype wire

/* bench/sfd_result_checker.sv */
// Checker that predicts the deframer's result beats from its input beats and compares them.
`timescale 1ns / 1ps

module sfd_result_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [16:0] frame_position_i,
  input  wire logic [15:0] bin_length_i,
  input  wire logic [7:0]  tx_node_i,
  input  wire logic [7:0]  rx_node_i,
  input  wire logic [7:0]  msg_count_i,
  input  wire logic [7:0]  msg_type_i,
  output int               mismatch_count_o,
  output int               pending_count_o
);
  import sfd_pkg::*;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_HEADER,
    PH_PAYLOAD
  } parse_phase_e;

  // Shadow copy of the frame parser.
  parse_phase_e phase_q;
  logic [16:0]  pos_q;
  logic [15:0]  len_q;
  logic [7:0]   tx_q;
  logic [7:0]   rx_q;
  logic [7:0]   count_q;
  logic [7:0]   type_q;

  result_t predicted_beats[$];
  int      mismatches;

  task automatic report(input string msg);
    if (mismatches < 40) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  task automatic tag_beat(input logic [1:0] kind, input logic [7:0] b);
    result_t r;
    r.kind           = kind;
    r.data_byte      = b;
    r.frame_position = pos_q;
    r.bin_length     = len_q;
    r.tx_node        = tx_q;
    r.rx_node        = rx_q;
    r.msg_count      = count_q;
    r.msg_type       = type_q;
    predicted_beats = {predicted_beats, r};
  endtask

  // Advances the shadow parser by one received byte and queues any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    case (phase_q)
      PH_HEADER: begin
        pos_q = pos_q + 17'd1;
        if (pos_q == POS_LEN_LO) begin
          len_q = {8'h00, b};
        end else if (pos_q == POS_LEN_HI) begin
          len_q[15:8] = b;
        end else if (pos_q == POS_TX) begin
          tx_q = b;
        end else if (pos_q == POS_RX) begin
          rx_q = b;
        end else if (pos_q == POS_COUNT) begin
          count_q = b;
        end else if (pos_q > POS_COUNT) begin
          type_q = b;
          if (len_q < MIN_LENGTH) begin
            tag_beat(KIND_BAD_LEN, b);
            phase_q = PH_SCAN;
          end else begin
            phase_q = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pos_q = pos_q + 17'd1;
        if (pos_q == {1'b0, len_q} + TERM_OFFSET) begin
          tag_beat((b == LINE_FEED) ? KIND_END_OK : KIND_BAD_TERM, b);
          phase_q = PH_SCAN;
        end else begin
          tag_beat(KIND_PAYLOAD, b);
        end
      end
      default: begin
        phase_q = PH_SCAN;
        if (b == START_CHAR) begin
          pos_q   = 17'd1;
          len_q   = '0;
          tx_q    = '0;
          rx_q    = '0;
          count_q = '0;
          type_q  = '0;
          phase_q = PH_HEADER;
        end
      end
    endcase
  endtask

  task automatic compare_beat();
    result_t want;
    if (predicted_beats.size() == 0) begin
      report($sformatf("result beat kind %0d byte %0h with nothing predicted",
                       kind_i, data_byte_i));
    end else begin
      want = predicted_beats.pop_front();
      check_field("kind", 32'(kind_i), 32'(want.kind));
      check_field("data_byte", 32'(data_byte_i), 32'(want.data_byte));
      check_field("frame_position", 32'(frame_position_i), 32'(want.frame_position));
      check_field("bin_length", 32'(bin_length_i), 32'(want.bin_length));
      check_field("tx_node", 32'(tx_node_i), 32'(want.tx_node));
      check_field("rx_node", 32'(rx_node_i), 32'(want.rx_node));
      check_field("msg_count", 32'(msg_count_i), 32'(want.msg_count));
      check_field("msg_type", 32'(msg_type_i), 32'(want.msg_type));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    = PH_SCAN;
      pos_q      = '0;
      len_q      = '0;
      tx_q       = '0;
      rx_q       = '0;
      count_q    = '0;
      type_q     = '0;
      mismatches = 0;
      predicted_beats.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_beat();
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i);
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= predicted_beats.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the deframer bench: clock, reset, byte stream stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import sfd_pkg::*;

  localparam int ITEM_TARGET     = 1750;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES    = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [16:0] frame_position_o;
  logic [15:0] bin_length_o;
  logic [7:0]  tx_node_o;
  logic [7:0]  rx_node_o;
  logic [7:0]  msg_count_o;
  logic [7:0]  msg_type_o;

  int mismatch_total;
  int pending_results;

  // When calm is set, neither side inserts random gaps or stalls.
  bit calm;
  // A request from the stimulus side for one long receiver hold-off.
  bit hold_req;
  // Counts frame bytes offered to the block; stray bytes while hunting do not count.
  int items_sent;

  sonar_frame_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .frame_position_o (frame_position_o),
    .bin_length_o     (bin_length_o),
    .tx_node_o        (tx_node_o),
    .rx_node_o        (rx_node_o),
    .msg_count_o      (msg_count_o),
    .msg_type_o       (msg_type_o)
  );

  sfd_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .data_byte_i      (data_byte_o),
    .frame_position_i (frame_position_o),
    .bin_length_i     (bin_length_o),
    .tx_node_i        (tx_node_o),
    .rx_node_i        (rx_node_o),
    .msg_count_i      (msg_count_o),
    .msg_type_i       (msg_type_o),
    .mismatch_count_o (mismatch_total),
    .pending_count_o  (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one byte and returns at the falling edge after the beat was taken.
  // It is entered at a falling edge. Valid is lowered only for a random gap, and each
  // gap waits for a falling edge, so valid never gets two updates in one time step.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Sends a whole frame: start character, four skipped hex bytes, binary length,
  // the four header bytes, payload and terminator. Lengths below six end at the type byte,
  // which is where the block flags the bad length.
  task automatic send_frame(input logic [15:0] len, input logic [7:0] tx,
                            input logic [7:0] rx, input logic [7:0] cnt,
                            input logic [7:0] mtype, input bit good_term);
    int payload_bytes;
    send_byte(START_CHAR);
    repeat (4) send_byte(8'($urandom_range(255)));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(tx);
    send_byte(rx);
    send_byte(cnt);
    send_byte(mtype);
    items_sent += 11;
    if (len >= MIN_LENGTH) begin
      payload_bytes = int'(len) - int'(MIN_LENGTH);
      repeat (payload_bytes) send_byte(8'($urandom_range(255)));
      send_byte(good_term ? LINE_FEED : 8'($urandom_range(255)));
      items_sent += payload_bytes + 1;
    end
  endtask

  task automatic send_random_frame(input logic [15:0] len, input bit good_term);
    send_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)), good_term);
  endtask

  // Stimulus: reset, a short directed part, then mostly well-formed frames with random
  // content, mixed with stray bytes and frames that are cut short by a lone start character.
  initial begin
    int frame_no;
    int roll;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    calm       = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Stray bytes while hunting, including both extremes, are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    // The shortest legal frame: the terminator follows the header directly.
    send_frame(16'd6, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // A length below six is flagged on the type byte.
    send_frame(16'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

    frame_no = 0;
    while (items_sent < ITEM_TARGET) begin
      frame_no++;
      // A stretch of frames with no gaps and no stalls at all.
      calm = (frame_no >= 20 && frame_no < 32);
      roll = $urandom_range(99);
      if (frame_no == 5 || frame_no == 40) begin
        // The receiver holds off while this frame streams in, so the block fills up.
        hold_req = 1'b1;
        send_random_frame(16'd200, 1'b1);
      end else if (roll < 12) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (roll < 22) begin
        send_random_frame(16'($urandom_range(0, 5)), 1'b1);
      end else if (roll < 27) begin
        // A start character whose frame is broken off: the next frame's bytes
        // become its header and payload.
        send_byte(START_CHAR);
        items_sent++;
      end else begin
        send_random_frame(16'($urandom_range(6, 40)), $urandom_range(99) < 75);
      end
    end

    // A frame header with the largest length, so the upper length bits show up in the
    // results. Only a short part of its payload follows and the run ends inside it.
    calm = 1'b0;
    send_byte(START_CHAR);
    repeat (4) send_byte(8'($urandom_range(255)));
    send_byte(8'hFF);
    send_byte(8'hFF);
    repeat (4) send_byte(8'($urandom_range(255)));
    repeat (24) send_byte(8'($urandom_range(255)));
    items_sent += 35;

    in_valid_i <= 1'b0;
    while (pending_results != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_total == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 17);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sonar_frame_deframer.f */
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sonar_frame_deframer.sv
bench/sfd_result_checker.sv
bench/testbench.sv
